### src/psd_pkg.sv
// ----------------------------------------------------------------------------
// psd_pkg
// Shared types, widths, register indexes and reset values of the phase-space
// period detector.
// ----------------------------------------------------------------------------
package psd_pkg;

	// Default sizes of the block
	localparam int MAX_DIMS_DEF      = 8;
	localparam int MAX_DELAY_DEF     = 512;
	localparam int HISTORY_DEPTH_DEF = 4096;

	// Field and register widths
	localparam int SAMPLE_W   = 16;
	localparam int COUNT_W    = 16;
	localparam int FREQ_W     = 18;
	localparam int DELAY_W    = 10;
	localparam int BLEN_W     = 16;
	localparam int DIMS_W     = 4;
	localparam int TOL_W      = 36;
	localparam int MINIT_W    = 16;
	localparam int RATE_W     = 18;
	localparam int CFG_DATA_W = 36;
	localparam int CFG_IDX_W  = 3;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	// Register indexes
	localparam cfg_idx_t CFG_DELAY_K      = 3'd0;
	localparam cfg_idx_t CFG_BATCH_LEN    = 3'd1;
	localparam cfg_idx_t CFG_DIMENSIONS   = 3'd2;
	localparam cfg_idx_t CFG_TOLERANCE_SQ = 3'd3;
	localparam cfg_idx_t CFG_MIN_ITER     = 3'd4;
	localparam cfg_idx_t CFG_SAMPLE_RATE  = 3'd5;

	// Register reset values
	localparam logic [DELAY_W-1:0] DELAY_K_RST      = 10'd1;
	localparam logic [BLEN_W-1:0]  BATCH_LEN_RST    = 16'd1024;
	localparam logic [DIMS_W-1:0]  DIMENSIONS_RST   = 4'd3;
	localparam logic [TOL_W-1:0]   TOLERANCE_SQ_RST = 36'd107374;
	localparam logic [MINIT_W-1:0] MIN_ITER_RST     = 16'd50;
	localparam logic [RATE_W-1:0]  SAMPLE_RATE_RST  = 18'd44100;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SETUP,
		ST_TAP_RD,
		ST_TAP_USE,
		ST_SQUARE,
		ST_ACCUM,
		ST_REDUCE,
		ST_FINISH,
		ST_DIVIDE,
		ST_OUTPUT
	} psd_state_t;

	// Divider status toward the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

### src/psd_history.sv
// ----------------------------------------------------------------------------
// psd_history
// Sample history memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module psd_history #(
	parameter int DEPTH = psd_pkg::HISTORY_DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [AW-1:0]                 waddr,
	input  logic [psd_pkg::SAMPLE_W-1:0]  wdata,
	input  logic [AW-1:0]                 raddr,
	output logic [psd_pkg::SAMPLE_W-1:0]  rdata
);

	logic [psd_pkg::SAMPLE_W-1:0] mem [DEPTH];
	logic [psd_pkg::SAMPLE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### src/psd_divider.sv
// ----------------------------------------------------------------------------
// psd_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module psd_divider #(
	parameter int NUM_W = psd_pkg::RATE_W,
	parameter int DEN_W = psd_pkg::COUNT_W
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [NUM_W-1:0]     num,
	input  logic [DEN_W-1:0]     den,
	output logic [NUM_W-1:0]     quotient,
	output psd_pkg::div_status_t status
);

	localparam int CW = $clog2(NUM_W + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;

	logic [DEN_W:0]   shifted;
	logic [DEN_W:0]   trial;
	logic             ge;

	assign shifted = {rem_q, quo_q[NUM_W-1]};
	assign ge      = shifted >= {1'b0, den_q};
	assign trial   = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			quo_q <= {quo_q[NUM_W-2:0], ge};
			rem_q <= ge ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
		end
	end

	assign quotient    = quo_q;
	assign status.busy = busy_q;
	assign status.done = done_q;

endmodule

### src/phase_space_period_detector_top.sv
// ----------------------------------------------------------------------------
// phase_space_period_detector_top
// Pitch estimate by delay-embedding recurrence over batches of audio samples.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall with sample and end_of_stream. Output
// channel: out_valid / out_stall with period_count, frequency_hz, zero_count,
// recurred and last; at most one result per sample. Registers are written
// through cfg_we / cfg_index / cfg_data. The user must write them only while
// the block is idle; the block does not enforce this. One sequencer walks the
// D coordinates of a point through the history memory port, one read per
// coordinate: ST_TAP_RD, ST_TAP_USE and ST_REDUCE to capture an anchor, plus
// ST_SQUARE and ST_ACCUM to test against it; other samples go from ST_SETUP
// to ST_FINISH. ST_REDUCE repeats per extra wrap of a lag longer than the
// history. A sample that yields a result also waits for the bit-serial divide
// of sample_rate by the count. in_stall is high while a sample is in work. A
// finished result sits in the output register; a stalled receiver holds it,
// and the next sample is still taken, its result waiting for the register to
// free. Reset clears the registers to their defaults and restarts the stream;
// history entries not yet written read as zero, tracked by the write pointer
// and a wrap flag, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module phase_space_period_detector_top #(
	parameter int MAX_DIMS      = psd_pkg::MAX_DIMS_DEF,
	parameter int MAX_DELAY     = psd_pkg::MAX_DELAY_DEF,
	parameter int HISTORY_DEPTH = psd_pkg::HISTORY_DEPTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [psd_pkg::SAMPLE_W-1:0]  sample,
	input  logic                                 end_of_stream,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [psd_pkg::COUNT_W-1:0]          period_count,
	output logic [psd_pkg::FREQ_W-1:0]           frequency_hz,
	output logic                                 zero_count,
	output logic                                 recurred,
	output logic                                 last,
	input  logic                                 cfg_we,
	input  psd_pkg::cfg_idx_t                    cfg_index,
	input  logic [psd_pkg::CFG_DATA_W-1:0]       cfg_data
);

	localparam int SW_S      = psd_pkg::SAMPLE_W;
	localparam int AW        = $clog2(HISTORY_DEPTH);
	localparam int DW        = $clog2(MAX_DIMS + 1);
	localparam int AIW       = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam int KW        = $clog2(MAX_DELAY + 1);
	localparam int PW        = DW + KW;
	localparam int MAX_START = (MAX_DIMS - 1) * MAX_DELAY;
	localparam int SIW       = $clog2(MAX_START + 1) + 1;
	localparam int RW        = ((AW > KW) ? AW : KW) + 2;
	localparam int SQ_W      = 2 * SW_S;
	localparam int SUM_W     = SQ_W + $clog2(MAX_DIMS);
	localparam int CMP_W     = (SUM_W > psd_pkg::TOL_W) ? SUM_W : psd_pkg::TOL_W;
	localparam int CNT_W     = psd_pkg::COUNT_W;

	// Configuration
	logic [psd_pkg::DELAY_W-1:0] delay_k_q;
	logic [psd_pkg::BLEN_W-1:0]  batch_len_q;
	logic [psd_pkg::DIMS_W-1:0]  dimensions_q;
	logic [psd_pkg::TOL_W-1:0]   tolerance_sq_q;
	logic [psd_pkg::MINIT_W-1:0] min_iter_q;
	logic [psd_pkg::RATE_W-1:0]  sample_rate_q;

	// Control state
	psd_pkg::psd_state_t state_q, state_n;
	logic [AW-1:0]       wr_ptr_q;
	logic                wrapped_q;
	logic [SIW-1:0]      sidx_q;
	logic                begun_q;
	logic [CNT_W-1:0]    boff_q;
	logic [CNT_W-1:0]    iter_q;
	logic                searching_q;
	logic signed [SW_S-1:0] anchor_q [MAX_DIMS];
	logic [DW-1:0]       d_q;
	logic                capture_q;
	logic                out_valid_q;

	// Item payload and work registers
	logic [AW-1:0]       cur_q;
	logic                eos_q;
	logic [AW-1:0]       pos_q;
	logic signed [RW-1:0] acc_q;
	logic signed [SW_S:0] diff_q;
	logic [SQ_W-1:0]     sq_q;
	logic [SUM_W-1:0]    sum_q;
	logic [CNT_W-1:0]    res_cnt_q;
	logic                res_rec_q;
	logic                res_last_q;
	logic [CNT_W-1:0]    period_count_q;
	logic [psd_pkg::FREQ_W-1:0] frequency_hz_q;
	logic                zero_count_q;
	logic                recurred_q;
	logic                last_q;

	// Effective configuration
	logic [DW-1:0]       d_eff;
	logic [KW-1:0]       k_eff;
	logic [CNT_W-1:0]    l_eff;
	logic [SIW-1:0]      start_w;

	always_comb begin
		if (dimensions_q == '0) begin
			d_eff = DW'(1);
		end else if (32'(dimensions_q) > 32'(MAX_DIMS)) begin
			d_eff = DW'(MAX_DIMS);
		end else begin
			d_eff = DW'(dimensions_q);
		end
		if (delay_k_q == '0) begin
			k_eff = KW'(1);
		end else if (32'(delay_k_q) > 32'(MAX_DELAY)) begin
			k_eff = KW'(MAX_DELAY);
		end else begin
			k_eff = KW'(delay_k_q);
		end
		l_eff   = (batch_len_q == '0) ? CNT_W'(1) : batch_len_q;
		start_w = SIW'(PW'(d_eff - DW'(1)) * PW'(k_eff));
	end

	// History memory
	logic                accept;
	logic [SW_S-1:0]     rdata;

	assign accept = (state_q == psd_pkg::ST_IDLE) && in_valid;

	psd_history #(
		.DEPTH (HISTORY_DEPTH),
		.AW    (AW)
	) u_history (
		.clk   (clk),
		.we    (accept),
		.waddr (wr_ptr_q),
		.wdata (sample),
		.raddr (pos_q),
		.rdata (rdata)
	);

	// Tap value: entries not yet written read as zero
	logic                   tap_ok;
	logic signed [SW_S-1:0] tap_val;
	logic signed [SW_S-1:0] anc_val;
	logic [SW_S:0]          mag;
	logic [SQ_W-1:0]        sq_w;

	assign tap_ok  = wrapped_q || (pos_q <= cur_q);
	assign tap_val = tap_ok ? $signed(rdata) : '0;
	assign anc_val = anchor_q[d_q[AIW-1:0]];
	assign mag     = diff_q[SW_S] ? SW_S'(0) - diff_q : diff_q;
	assign sq_w    = mag[SW_S-1:0] * mag[SW_S-1:0];

	// Setup decisions
	logic             begun_n;
	logic [CNT_W-1:0] boff_n;
	logic             capture_n;
	logic             loop_go;

	always_comb begin
		begun_n   = begun_q || (sidx_q >= start_w);
		boff_n    = begun_q ? boff_q : '0;
		capture_n = (boff_n == '0);
		loop_go   = begun_n && (capture_n || (searching_q && (iter_q >= min_iter_q)));
	end

	// End-of-item decisions
	logic             anchor_step;
	logic             hit;
	logic             srch_a;
	logic [CNT_W-1:0] iter_a;
	logic             end_batch;
	logic             srch_b;
	logic             emit;
	logic [CNT_W-1:0] emit_cnt;
	logic [CNT_W-1:0] boff_inc;
	logic [CNT_W-1:0] boff_fin;

	always_comb begin
		anchor_step = (boff_q == '0);
		hit         = begun_q && !anchor_step && searching_q && (iter_q >= min_iter_q) &&
		              (CMP_W'(sum_q) <= CMP_W'(tolerance_sq_q));
		srch_a      = searching_q;
		iter_a      = iter_q;
		if (begun_q) begin
			if (anchor_step) begin
				srch_a = 1'b1;
				iter_a = '0;
			end else if (searching_q) begin
				if (hit) begin
					srch_a = 1'b0;
				end else if (iter_q != '1) begin
					iter_a = iter_q + CNT_W'(1);
				end
			end
		end
		end_batch = begun_q && srch_a && (boff_q >= l_eff - CNT_W'(1));
		srch_b    = srch_a && !end_batch;
		emit      = hit || end_batch || (eos_q && srch_b);
		emit_cnt  = hit ? iter_q : iter_a;
		boff_inc  = boff_q + CNT_W'(1);
		if (!begun_q) begin
			boff_fin = boff_q;
		end else if (boff_inc >= l_eff) begin
			boff_fin = '0;
		end else begin
			boff_fin = boff_inc;
		end
	end

	// Divider
	logic                          div_start;
	logic [psd_pkg::RATE_W-1:0]    quotient;
	psd_pkg::div_status_t          div_st;

	psd_divider #(
		.NUM_W (psd_pkg::RATE_W),
		.DEN_W (CNT_W)
	) u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.num      (sample_rate_q),
		.den      (emit_cnt),
		.quotient (quotient),
		.status   (div_st)
	);

	logic out_free;
	assign out_free = !out_valid_q || !out_stall;

	// Next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			psd_pkg::ST_IDLE:    if (in_valid) state_n = psd_pkg::ST_SETUP;
			psd_pkg::ST_SETUP:   state_n = loop_go ? psd_pkg::ST_TAP_RD : psd_pkg::ST_FINISH;
			psd_pkg::ST_TAP_RD:  state_n = psd_pkg::ST_TAP_USE;
			psd_pkg::ST_TAP_USE: state_n = capture_q ? psd_pkg::ST_REDUCE : psd_pkg::ST_SQUARE;
			psd_pkg::ST_SQUARE:  state_n = psd_pkg::ST_ACCUM;
			psd_pkg::ST_ACCUM:   state_n = psd_pkg::ST_REDUCE;
			psd_pkg::ST_REDUCE: begin
				if (!acc_q[RW-1]) begin
					state_n = (DW'(d_q + DW'(1)) == d_eff) ? psd_pkg::ST_FINISH
					                                       : psd_pkg::ST_TAP_RD;
				end
			end
			psd_pkg::ST_FINISH:  state_n = emit ? psd_pkg::ST_DIVIDE : psd_pkg::ST_IDLE;
			psd_pkg::ST_DIVIDE:  if (div_st.done) state_n = psd_pkg::ST_OUTPUT;
			psd_pkg::ST_OUTPUT:  if (out_free) state_n = psd_pkg::ST_IDLE;
			default:             state_n = psd_pkg::ST_IDLE;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		in_stall  = (state_q != psd_pkg::ST_IDLE);
		div_start = (state_q == psd_pkg::ST_FINISH) && emit;
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= psd_pkg::ST_IDLE;
			delay_k_q      <= psd_pkg::DELAY_K_RST;
			batch_len_q    <= psd_pkg::BATCH_LEN_RST;
			dimensions_q   <= psd_pkg::DIMENSIONS_RST;
			tolerance_sq_q <= psd_pkg::TOLERANCE_SQ_RST;
			min_iter_q     <= psd_pkg::MIN_ITER_RST;
			sample_rate_q  <= psd_pkg::SAMPLE_RATE_RST;
			wr_ptr_q       <= '0;
			wrapped_q      <= 1'b0;
			sidx_q         <= '0;
			begun_q        <= 1'b0;
			boff_q         <= '0;
			iter_q         <= '0;
			searching_q    <= 1'b0;
			for (int i = 0; i < MAX_DIMS; i++) begin
				anchor_q[i] <= '0;
			end
			d_q            <= '0;
			capture_q      <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			state_q <= state_n;

			if (cfg_we) begin
				unique case (cfg_index)
					psd_pkg::CFG_DELAY_K:      delay_k_q      <= cfg_data[psd_pkg::DELAY_W-1:0];
					psd_pkg::CFG_BATCH_LEN:    batch_len_q    <= cfg_data[psd_pkg::BLEN_W-1:0];
					psd_pkg::CFG_DIMENSIONS:   dimensions_q   <= cfg_data[psd_pkg::DIMS_W-1:0];
					psd_pkg::CFG_TOLERANCE_SQ: tolerance_sq_q <= cfg_data[psd_pkg::TOL_W-1:0];
					psd_pkg::CFG_MIN_ITER:     min_iter_q     <= cfg_data[psd_pkg::MINIT_W-1:0];
					psd_pkg::CFG_SAMPLE_RATE:  sample_rate_q  <= cfg_data[psd_pkg::RATE_W-1:0];
					default: ;
				endcase
			end

			if (accept) begin
				if (wr_ptr_q == AW'(HISTORY_DEPTH - 1)) begin
					wr_ptr_q  <= '0;
					wrapped_q <= 1'b1;
				end else begin
					wr_ptr_q <= wr_ptr_q + AW'(1);
				end
			end

			unique case (state_q)
				psd_pkg::ST_SETUP: begin
					begun_q   <= begun_n;
					boff_q    <= boff_n;
					d_q       <= '0;
					capture_q <= capture_n;
				end
				psd_pkg::ST_TAP_USE: begin
					if (capture_q) begin
						anchor_q[d_q[AIW-1:0]] <= tap_val;
					end
				end
				psd_pkg::ST_REDUCE: begin
					if (!acc_q[RW-1]) begin
						d_q <= d_q + DW'(1);
					end
				end
				psd_pkg::ST_FINISH: begin
					// end of stream drops the open batch and restarts indexing
					if (eos_q) begin
						sidx_q      <= '0;
						begun_q     <= 1'b0;
						boff_q      <= '0;
						iter_q      <= '0;
						searching_q <= 1'b0;
					end else begin
						if (sidx_q != '1) begin
							sidx_q <= sidx_q + SIW'(1);
						end
						boff_q      <= boff_fin;
						iter_q      <= iter_a;
						searching_q <= srch_b;
					end
				end
				default: ;
			endcase

			if (state_q == psd_pkg::ST_OUTPUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Work and result registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cur_q <= wr_ptr_q;
			eos_q <= end_of_stream;
		end
		unique case (state_q)
			psd_pkg::ST_SETUP: begin
				pos_q <= cur_q;
				sum_q <= '0;
			end
			psd_pkg::ST_TAP_USE: begin
				diff_q <= {tap_val[SW_S-1], tap_val} - {anc_val[SW_S-1], anc_val};
				acc_q  <= $signed(RW'(pos_q)) - $signed(RW'(k_eff));
			end
			psd_pkg::ST_SQUARE: begin
				sq_q <= sq_w;
			end
			psd_pkg::ST_ACCUM: begin
				sum_q <= sum_q + SUM_W'(sq_q);
			end
			psd_pkg::ST_REDUCE: begin
				// fold the lag back into the circular history
				if (acc_q[RW-1]) begin
					acc_q <= acc_q + $signed(RW'(HISTORY_DEPTH));
				end else begin
					pos_q <= acc_q[AW-1:0];
				end
			end
			psd_pkg::ST_FINISH: begin
				res_cnt_q  <= emit_cnt;
				res_rec_q  <= hit;
				res_last_q <= eos_q;
			end
			default: ;
		endcase
		if (state_q == psd_pkg::ST_OUTPUT && out_free) begin
			period_count_q <= res_cnt_q;
			frequency_hz_q <= (res_cnt_q == '0) ? '0 : quotient;
			zero_count_q   <= (res_cnt_q == '0);
			recurred_q     <= res_rec_q;
			last_q         <= res_last_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign period_count = period_count_q;
	assign frequency_hz = frequency_hz_q;
	assign zero_count   = zero_count_q;
	assign recurred     = recurred_q;
	assign last         = last_q;

`ifndef ASSERT_OFF
	a_zero_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((zero_count == (period_count == '0)) &&
		               (!zero_count || (frequency_hz == '0))))
		else $error("zero count result carries nonzero fields");

	a_div_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_st.busy)
		else $error("divider started while busy");

	a_coord_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == psd_pkg::ST_TAP_USE) |-> (d_q < d_eff))
		else $error("coordinate index past dimension count");

	a_div_then_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == psd_pkg::ST_FINISH && emit) |=> (state_q == psd_pkg::ST_DIVIDE && div_st.busy))
		else $error("result not handed to divider");
`endif

endmodule
